@@ hdl/csvp_pkg.sv @@
// ----------------------------------------------------------------------------
// csvp_pkg
// Shared types and constants for the comma-separated decimal line parser.
// ----------------------------------------------------------------------------
package csvp_pkg;

  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [1:0] LastField = 2'd3;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SIGN   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_DONE   = 3'd3,
    PH_FAIL   = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0]  temp;
    logic [7:0]  fuel;
    logic [15:0] rpm;
    logic [15:0] speed;
  } fields_t;

  typedef struct packed {
    logic    parse_ok;
    fields_t values;
  } result_t;

  // Write one finished value into its slot, cut to the slot width.
  function automatic fields_t store_field(fields_t f, logic [1:0] idx, logic [15:0] v);
    fields_t r;
    r = f;
    case (idx)
      2'd0:    r.speed = v;
      2'd1:    r.rpm   = v;
      2'd2:    r.fuel  = v[7:0];
      default: r.temp  = v[7:0];
    endcase
    return r;
  endfunction

endpackage

@@ hdl/csv_line_decimal_parser.sv @@
// ----------------------------------------------------------------------------
// csv_line_decimal_parser
// Streaming parser for "speed,rpm,fuel,temp" lines of decimal integers.
// ----------------------------------------------------------------------------
// Feed received bytes one per transaction on the input channel; the block
// takes one byte every clock cycle while no LF waits in the input register.
// Each byte lands in an input register, from which the parse stage advances
// the line state; when it takes an LF, the result goes into the output
// register. Only an LF produces a result transaction: parse_ok tells whether
// the line held four well-formed fields, and the four value ports always
// carry the latched values, which change only on a good line. CR bytes are
// dropped, bytes past the first LINE_CAP-1 of a line are ignored, and the
// values wrap to 16, 16, 8 and 8 bits (negatives in two's complement). An
// LF waits in the input register only while a previous result is still
// stalled at the output; all other bytes pass regardless of the output.
module csv_line_decimal_parser #(
  parameter int LINE_CAP = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_char_i,
  // result output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        parse_ok_o,
  output logic [15:0] speed_value_o,
  output logic [15:0] rpm_value_o,
  output logic [7:0]  fuel_value_o,
  output logic [7:0]  temp_value_o
);
  import csvp_pkg::*;

  // Input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_char_q;
  logic       in_accept;
  logic       s1_is_lf;
  logic       s1_go;

  // Result register
  logic    out_valid_q, out_valid_d;
  result_t out_res_q;
  result_t parse_res;
  logic    out_load;

  assign s1_is_lf = (s1_char_q == CharLf);
  // Advance the held byte unless it is an LF and the result slot is full and stalled.
  assign s1_go    = s1_valid_q && (!s1_is_lf || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = s1_go && s1_is_lf;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      // Drop the result once the transaction completes.
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold unless new data is taken.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_char_q <= rx_char_i;
    end
    if (out_load) begin
      out_res_q <= parse_res;
    end
  end

  csvp_parser #(
    .LINE_CAP (LINE_CAP)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (s1_go),
    .char_i (s1_char_q),
    .res_o  (parse_res)
  );

  assign out_valid_o   = out_valid_q;
  assign parse_ok_o    = out_res_q.parse_ok;
  assign speed_value_o = out_res_q.values.speed;
  assign rpm_value_o   = out_res_q.values.rpm;
  assign fuel_value_o  = out_res_q.values.fuel;
  assign temp_value_o  = out_res_q.values.temp;

endmodule

@@ hdl/csvp_parser.sv @@
// ----------------------------------------------------------------------------
// csvp_parser
// Line state of the parser: field scanner, accumulator and latched values.
// ----------------------------------------------------------------------------
module csvp_parser #(
  parameter int LINE_CAP = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        char_i,
  output csvp_pkg::result_t res_o
);
  import csvp_pkg::*;

  localparam int CntW = $clog2(LINE_CAP);
  localparam logic [CntW-1:0] CountMax = CntW'(LINE_CAP - 1);

  logic [CntW-1:0] count_q, count_d;
  logic [1:0]      idx_q, idx_d;
  phase_e          phase_q, phase_d;
  logic            neg_q, neg_d;
  logic [15:0]     acc_q, acc_d;
  fields_t         pend_q, pend_d;
  fields_t         latch_q, latch_d;

  logic        is_digit;
  logic        is_blank;
  logic [15:0] digit_val;
  logic [15:0] signed_val;
  logic        line_ok;
  fields_t     pend_final;

  assign is_digit   = char_i inside {[CharZero:CharNine]};
  assign is_blank   = char_i inside {8'h20, 8'h09, 8'h0B, 8'h0C, CharLf, CharCr};
  assign digit_val  = {8'h00, char_i - CharZero};
  assign signed_val = neg_q ? (16'd0 - acc_q) : acc_q;
  assign line_ok    = (phase_q == PH_DONE) ||
                      ((phase_q == PH_DIGITS) && (idx_q == LastField));
  assign pend_final = (phase_q == PH_DIGITS) ? store_field(pend_q, idx_q, signed_val)
                                              : pend_q;

  always_comb begin
    count_d = count_q;
    idx_d   = idx_q;
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    pend_d  = pend_q;
    latch_d = latch_q;
    if (take_i) begin
      if (char_i == CharLf) begin
        if (line_ok) begin
          latch_d = pend_final;
        end
        count_d = '0;
        idx_d   = '0;
        phase_d = PH_START;
        neg_d   = 1'b0;
        acc_d   = '0;
        pend_d  = '0;
      end else if (char_i != CharCr && count_q < CountMax) begin
        count_d = count_q + 1'b1;
        case (phase_q)
          PH_START: begin
            if (is_blank) begin
              phase_d = PH_START;
            end else if (char_i == CharPlus || char_i == CharMinus) begin
              neg_d   = (char_i == CharMinus);
              phase_d = PH_SIGN;
            end else if (is_digit) begin
              acc_d   = digit_val;
              phase_d = PH_DIGITS;
            end else begin
              phase_d = PH_FAIL;
            end
          end
          PH_SIGN: begin
            if (is_digit) begin
              acc_d   = digit_val;
              phase_d = PH_DIGITS;
            end else begin
              phase_d = PH_FAIL;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              // acc * 10 + digit, modulo 2^16
              acc_d = {acc_q[12:0], 3'b000} + {acc_q[14:0], 1'b0} + digit_val;
            end else if (idx_q == LastField) begin
              pend_d  = store_field(pend_q, idx_q, signed_val);
              phase_d = PH_DONE;
            end else if (char_i == CharComma) begin
              pend_d  = store_field(pend_q, idx_q, signed_val);
              idx_d   = idx_q + 1'b1;
              neg_d   = 1'b0;
              acc_d   = '0;
              phase_d = PH_START;
            end else begin
              phase_d = PH_FAIL;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      phase_q <= PH_START;
      neg_q   <= 1'b0;
      acc_q   <= '0;
      pend_q  <= '0;
      latch_q <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      phase_q <= phase_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
      pend_q  <= pend_d;
      latch_q <= latch_d;
    end
  end

  assign res_o.parse_ok = line_ok;
  assign res_o.values   = latch_d;

endmodule
